// ===== hdl/rgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rgb_pkg;

    localparam int MAX_SIDE    = 4096;
    localparam int SIDE_W      = 13;
    localparam int COORD_W     = 12;
    localparam int CHAN_W      = 8;
    localparam int PROD_W      = 28;   // side times hundredths
    localparam int CTR_W       = 21;   // center position and offsets, Q.8
    localparam int DIST_W      = 22;   // distance and radius, Q.8
    localparam int SUM_W       = 43;   // sum of squared offsets
    localparam int SQRT_STAGES = DIST_W;
    localparam int SQRT_REM_W  = SUM_W + 1;
    localparam int TQ_W        = 16;
    localparam int TDIV_STAGES = TQ_W;
    localparam int Q16_W       = 17;
    localparam int ADIV_STAGES = 2;
    localparam int LERP_W      = 24;
    localparam int OP_W        = 14;
    localparam int ANUM_W      = 38;
    localparam int AQ1_W       = 25;   // num / 10000
    localparam int AP1_W       = ANUM_W - 4 + 32;
    localparam int AP2_W       = AQ1_W + 26;
    localparam int GA_W        = LERP_W + Q16_W;
    localparam int PM_W        = CHAN_W + Q16_W;
    localparam int NUM_W       = GA_W + 1;

    localparam logic [Q16_W-1:0]  ONE_Q16   = 17'h10000;
    localparam logic [OP_W-1:0]   OP_FULL   = 14'd10000;
    // ceil(2^41 / 625); exact floor(n / 625) for any n below 2^34
    localparam logic [31:0]       RECIP_625 = 32'd3518437209;
    // ceil(2^33 / 255); exact floor(n / 255) for any n below 2^25
    localparam logic [25:0]       RECIP_255 = 26'd33686019;

    localparam int LATENCY = 5 + SQRT_STAGES + TDIV_STAGES + 2 + ADIV_STAGES + 2;

    typedef enum logic [2:0] {
        CFG_WIDTH    = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_CENTER_C = 3'd2,
        CFG_OUTER_C  = 3'd3,
        CFG_CENTER_X = 3'd4,
        CFG_CENTER_Y = 3'd5,
        CFG_RADIUS   = 3'd6,
        CFG_OPACITY  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [LERP_W-1:0] red;
        logic [LERP_W-1:0] green;
        logic [LERP_W-1:0] blue;
    } gcol_t;

    // floor(prod * 256 / 10000) = floor(16 * prod / 625)
    function automatic logic [DIST_W-1:0] scale_q8(input logic [PROD_W-1:0] prod);
        logic [31:0] num;
        logic [63:0] full;
        num  = {prod, 4'b0000};
        full = {32'd0, num} * {32'd0, RECIP_625};
        return full[41 +: DIST_W];
    endfunction

    function automatic logic [LERP_W-1:0] lerp_q16(input logic [CHAN_W-1:0] c1,
                                                   input logic [CHAN_W-1:0] c2,
                                                   input logic [Q16_W-1:0]  t);
        logic [Q16_W-1:0]  tinv;
        logic [LERP_W:0]   s;
        tinv = ONE_Q16 - t;
        s = (LERP_W+1)'(c1) * (LERP_W+1)'(tinv) + (LERP_W+1)'(c2) * (LERP_W+1)'(t);
        return s[LERP_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rgb_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_vld,
    input  wire logic [rgb_pkg::SUM_W-1:0]   in_sum,
    input  wire rgb_pkg::pix_t               in_pix,
    output logic                             out_vld,
    output logic [rgb_pkg::DIST_W-1:0]       out_root,
    output rgb_pkg::pix_t                    out_pix
);
    import rgb_pkg::*;

    logic [SQRT_STAGES-1:0] vld_reg;
    logic [SQRT_REM_W-1:0]  rem_reg   [SQRT_STAGES];
    logic [SQRT_REM_W-1:0]  rem_next  [SQRT_STAGES];
    logic [DIST_W-1:0]      root_reg  [SQRT_STAGES];
    logic [DIST_W-1:0]      root_next [SQRT_STAGES];
    pix_t                   pix_reg   [SQRT_STAGES];

    // one root bit per stage, most significant first
    always_comb
    begin
        logic [SQRT_REM_W-1:0] rsrc;
        logic [SQRT_REM_W-1:0] trial;
        logic [DIST_W-1:0]     qsrc;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            if (k == 0)
            begin
                rsrc = SQRT_REM_W'(in_sum);
                qsrc = '0;
            end
            else
            begin
                rsrc = rem_reg[k-1];
                qsrc = root_reg[k-1];
            end
            trial = ((SQRT_REM_W'(qsrc) << 1) | (SQRT_REM_W'(1) << (SQRT_STAGES-1-k)))
                    << (SQRT_STAGES-1-k);
            if (rsrc >= trial)
            begin
                rem_next[k]  = rsrc - trial;
                root_next[k] = qsrc | (DIST_W'(1) << (SQRT_STAGES-1-k));
            end
            else
            begin
                rem_next[k]  = rsrc;
                root_next[k] = qsrc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[SQRT_STAGES-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            pix_reg[k]  <= (k == 0) ? in_pix : pix_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign out_vld  = vld_reg[SQRT_STAGES-1];
    assign out_root = root_reg[SQRT_STAGES-1];
    assign out_pix  = pix_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/radial_gradient_blend_top.sv =====
// Radial gradient blend, fully pipelined: one pixel per clock, every clock.
// The 22-stage square root, the 16 one-bit t divide stages and the two-stage reciprocal
// alpha scaling make up most of the pipeline depth.
// busy stays low and the receiver cannot stall: there is no back pressure at all.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module radial_gradient_blend_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [11:0] pos_x,
    input  wire logic [11:0] pos_y,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    output logic             done,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import rgb_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Every write transfer is taken at once.
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic [31:0]       center_c_reg;
    logic [31:0]       outer_c_reg;
    logic [13:0]       center_x_reg;
    logic [13:0]       center_y_reg;
    logic [14:0]       radius_reg;
    logic [OP_W-1:0]   opacity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= SIDE_W'(1);
            height_reg   <= SIDE_W'(1);
            center_c_reg <= 32'hFFFF_FFFF;
            outer_c_reg  <= 32'hFF00_0000;
            center_x_reg <= 14'd5000;
            center_y_reg <= 14'd5000;
            radius_reg   <= 15'd5000;
            opacity_reg  <= 14'd10000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:    width_reg    <= cfg_data[SIDE_W-1:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[SIDE_W-1:0];
                CFG_CENTER_C: center_c_reg <= cfg_data;
                CFG_OUTER_C:  outer_c_reg  <= cfg_data;
                CFG_CENTER_X: center_x_reg <= cfg_data[13:0];
                CFG_CENTER_Y: center_y_reg <= cfg_data[13:0];
                CFG_RADIUS:   radius_reg   <= cfg_data[14:0];
                CFG_OPACITY:  opacity_reg  <= cfg_data[OP_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Derived geometry: a free-running two-stage pipe off the registers.
    // Pixels read it only from their third stage on, so a pixel that
    // arrives right after a write already sees the new values.
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] w_sat;
    logic [SIDE_W-1:0] h_sat;
    logic [SIDE_W-1:0] side;
    logic [PROD_W-1:0] px_prod_reg;
    logic [PROD_W-1:0] py_prod_reg;
    logic [PROD_W-1:0] pr_prod_reg;
    logic [CTR_W-1:0]  cx_reg;
    logic [CTR_W-1:0]  cy_reg;
    logic [DIST_W-1:0] rpx_reg;
    logic [OP_W-1:0]   op_sat;
    logic              pass;

    assign w_sat  = (width_reg  > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_reg;
    assign h_sat  = (height_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_reg;
    assign side   = (w_sat > h_sat) ? w_sat : h_sat;
    assign op_sat = (opacity_reg > OP_FULL) ? OP_FULL : opacity_reg;
    assign pass   = (opacity_reg == '0) || (radius_reg == '0);

    always_ff @(posedge clk)
    begin
        px_prod_reg <= PROD_W'(w_sat) * PROD_W'(center_x_reg);
        py_prod_reg <= PROD_W'(h_sat) * PROD_W'(center_y_reg);
        pr_prod_reg <= PROD_W'(side)  * PROD_W'(radius_reg);
        cx_reg      <= CTR_W'(scale_q8(px_prod_reg));
        cy_reg      <= CTR_W'(scale_q8(py_prod_reg));
        rpx_reg     <= scale_q8(pr_prod_reg);
    end

    // ------------------------------------------------------------------
    // Front: capture, settle, offsets, squares, sum.
    // ------------------------------------------------------------------
    logic                 acc;
    logic [4:0]           fr_vld_reg;
    logic [COORD_W-1:0]   s0_x_reg, s0_y_reg, s1_x_reg, s1_y_reg;
    pix_t                 s0_pix_reg, s1_pix_reg, s2_pix_reg, s3_pix_reg, s4_pix_reg;
    logic [CTR_W-1:0]     xq, yq;
    logic [CTR_W-1:0]     dx_reg, dy_reg;
    logic [2*CTR_W-1:0]   dx2_reg, dy2_reg;
    logic [SUM_W-1:0]     sum_reg;

    assign acc  = start && !busy;
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_vld_reg <= '0;
        else
            fr_vld_reg <= {fr_vld_reg[3:0], acc};
    end

    assign xq = CTR_W'({s1_x_reg, 8'h00});
    assign yq = CTR_W'({s1_y_reg, 8'h00});

    always_ff @(posedge clk)
    begin
        s0_x_reg   <= pos_x;
        s0_y_reg   <= pos_y;
        s0_pix_reg <= '{red: red_in, green: green_in, blue: blue_in};
        // hold for one more register so the derived geometry is current
        s1_x_reg   <= s0_x_reg;
        s1_y_reg   <= s0_y_reg;
        s1_pix_reg <= s0_pix_reg;
        dx_reg     <= (xq >= cx_reg) ? xq - cx_reg : cx_reg - xq;
        dy_reg     <= (yq >= cy_reg) ? yq - cy_reg : cy_reg - yq;
        s2_pix_reg <= s1_pix_reg;
        dx2_reg    <= (2*CTR_W)'(dx_reg) * (2*CTR_W)'(dx_reg);
        dy2_reg    <= (2*CTR_W)'(dy_reg) * (2*CTR_W)'(dy_reg);
        s3_pix_reg <= s2_pix_reg;
        sum_reg    <= SUM_W'(dx2_reg) + SUM_W'(dy2_reg);
        s4_pix_reg <= s3_pix_reg;
    end

    // ------------------------------------------------------------------
    // Distance: pipelined integer square root.
    // ------------------------------------------------------------------
    logic              sq_vld;
    logic [DIST_W-1:0] sq_root;
    pix_t              sq_pix;

    rgb_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (fr_vld_reg[4]),
        .in_sum   (sum_reg),
        .in_pix   (s4_pix_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_pix  (sq_pix)
    );

    // ------------------------------------------------------------------
    // t = dist / radius in Q0.16: one quotient bit per stage. The first
    // stage also flags dist >= radius, where t saturates to one (to zero if dist is zero).
    // ------------------------------------------------------------------
    logic [TDIV_STAGES-1:0] td_vld_reg;
    logic [DIST_W-1:0]      td_rem_reg  [TDIV_STAGES];
    logic [DIST_W-1:0]      td_rem_next [TDIV_STAGES];
    logic [TQ_W-1:0]        td_q_reg    [TDIV_STAGES];
    logic [TQ_W-1:0]        td_q_next   [TDIV_STAGES];
    logic [TDIV_STAGES-1:0] td_sat_reg;
    logic [TDIV_STAGES-1:0] td_zero_reg;
    pix_t                   td_pix_reg  [TDIV_STAGES];

    always_comb
    begin
        logic [DIST_W-1:0] rsrc;
        logic [TQ_W-1:0]   qsrc;
        logic [DIST_W:0]   r2;
        for (int k = 0; k < TDIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rsrc = sq_root;
                qsrc = '0;
            end
            else
            begin
                rsrc = td_rem_reg[k-1];
                qsrc = td_q_reg[k-1];
            end
            r2 = {rsrc, 1'b0};
            if (r2 >= {1'b0, rpx_reg})
            begin
                td_rem_next[k] = DIST_W'(r2 - {1'b0, rpx_reg});
                td_q_next[k]   = qsrc | (TQ_W'(1) << (TDIV_STAGES-1-k));
            end
            else
            begin
                td_rem_next[k] = r2[DIST_W-1:0];
                td_q_next[k]   = qsrc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            td_vld_reg <= '0;
        else
            td_vld_reg <= {td_vld_reg[TDIV_STAGES-2:0], sq_vld};
    end

    always_ff @(posedge clk)
    begin
        td_sat_reg  <= {td_sat_reg[TDIV_STAGES-2:0],  (sq_root >= rpx_reg)};
        td_zero_reg <= {td_zero_reg[TDIV_STAGES-2:0], (sq_root == '0)};
        for (int k = 0; k < TDIV_STAGES; k++)
        begin
            td_rem_reg[k] <= td_rem_next[k];
            td_q_reg[k]   <= td_q_next[k];
            td_pix_reg[k] <= (k == 0) ? sq_pix : td_pix_reg[(k == 0) ? 0 : k-1];
        end
    end

    // ------------------------------------------------------------------
    // Color and alpha lerp, then alpha times opacity.
    // ------------------------------------------------------------------
    logic [Q16_W-1:0]  t_val;
    logic              a1_vld_reg, a2_vld_reg;
    logic [LERP_W-1:0] a1_alerp_reg;
    gcol_t             a1_g_reg, a2_g_reg;
    pix_t              a1_pix_reg, a2_pix_reg;
    logic [ANUM_W-1:0] a2_num_reg;

    always_comb
    begin
        if (td_sat_reg[TDIV_STAGES-1])
            t_val = td_zero_reg[TDIV_STAGES-1] ? '0 : ONE_Q16;
        else
            t_val = Q16_W'(td_q_reg[TDIV_STAGES-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
        end
        else
        begin
            a1_vld_reg <= td_vld_reg[TDIV_STAGES-1];
            a2_vld_reg <= a1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_alerp_reg   <= lerp_q16(center_c_reg[31:24], outer_c_reg[31:24], t_val);
        a1_g_reg.red   <= lerp_q16(center_c_reg[7:0],   outer_c_reg[7:0],   t_val);
        a1_g_reg.green <= lerp_q16(center_c_reg[15:8],  outer_c_reg[15:8],  t_val);
        a1_g_reg.blue  <= lerp_q16(center_c_reg[23:16], outer_c_reg[23:16], t_val);
        a1_pix_reg     <= td_pix_reg[TDIV_STAGES-1];
        a2_num_reg     <= ANUM_W'(a1_alerp_reg) * ANUM_W'(op_sat);
        a2_g_reg       <= a1_g_reg;
        a2_pix_reg     <= a1_pix_reg;
    end

    // ------------------------------------------------------------------
    // alpha = num / (255 * 10000) = ((num >> 4) / 625) / 255: drop four
    // bits, then one reciprocal multiply per stage.
    // ------------------------------------------------------------------
    logic [ADIV_STAGES-1:0] ad_vld_reg;
    logic [AP1_W-1:0]       ad_p1;
    logic [AP2_W-1:0]       ad_p2;
    logic [AQ1_W-1:0]       ad_q1_reg;
    logic [Q16_W-1:0]       ad_q_reg;
    gcol_t                  ad_g_reg    [ADIV_STAGES];
    pix_t                   ad_pix_reg  [ADIV_STAGES];

    assign ad_p1 = AP1_W'(a2_num_reg[ANUM_W-1:4]) * AP1_W'(RECIP_625);
    assign ad_p2 = AP2_W'(ad_q1_reg) * AP2_W'(RECIP_255);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ad_vld_reg <= '0;
        else
            ad_vld_reg <= {ad_vld_reg[ADIV_STAGES-2:0], a2_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        ad_q1_reg <= ad_p1[41 +: AQ1_W];
        ad_q_reg  <= ad_p2[33 +: Q16_W];
        for (int k = 0; k < ADIV_STAGES; k++)
        begin
            ad_g_reg[k]   <= (k == 0) ? a2_g_reg   : ad_g_reg[(k == 0) ? 0 : k-1];
            ad_pix_reg[k] <= (k == 0) ? a2_pix_reg : ad_pix_reg[(k == 0) ? 0 : k-1];
        end
    end

    // ------------------------------------------------------------------
    // Blend: products, then sum, drop 32 fraction bits, clip.
    // ------------------------------------------------------------------
    logic [Q16_W-1:0]  alpha;
    logic [Q16_W-1:0]  alpha_inv;
    logic              b1_vld_reg;
    logic [GA_W-1:0]   b1_ga_r_reg, b1_ga_g_reg, b1_ga_b_reg;
    logic [PM_W-1:0]   b1_pm_r_reg, b1_pm_g_reg, b1_pm_b_reg;
    pix_t              b1_pix_reg;
    logic [NUM_W-1:0]  num_r, num_g, num_b;
    logic              out_vld_reg;
    logic [7:0]        red_out_reg, green_out_reg, blue_out_reg;

    assign alpha = (ad_q_reg > ONE_Q16) ? ONE_Q16 : ad_q_reg;
    assign alpha_inv = ONE_Q16 - alpha;

    always_ff @(posedge clk)
    begin
        b1_ga_r_reg <= GA_W'(ad_g_reg[ADIV_STAGES-1].red)   * GA_W'(alpha);
        b1_ga_g_reg <= GA_W'(ad_g_reg[ADIV_STAGES-1].green) * GA_W'(alpha);
        b1_ga_b_reg <= GA_W'(ad_g_reg[ADIV_STAGES-1].blue)  * GA_W'(alpha);
        b1_pm_r_reg <= PM_W'(ad_pix_reg[ADIV_STAGES-1].red)   * PM_W'(alpha_inv);
        b1_pm_g_reg <= PM_W'(ad_pix_reg[ADIV_STAGES-1].green) * PM_W'(alpha_inv);
        b1_pm_b_reg <= PM_W'(ad_pix_reg[ADIV_STAGES-1].blue)  * PM_W'(alpha_inv);
        b1_pix_reg  <= ad_pix_reg[ADIV_STAGES-1];
    end

    assign num_r = NUM_W'({b1_pm_r_reg, 16'h0000}) + NUM_W'(b1_ga_r_reg);
    assign num_g = NUM_W'({b1_pm_g_reg, 16'h0000}) + NUM_W'(b1_ga_g_reg);
    assign num_b = NUM_W'({b1_pm_b_reg, 16'h0000}) + NUM_W'(b1_ga_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            b1_vld_reg  <= ad_vld_reg[ADIV_STAGES-1];
            out_vld_reg <= b1_vld_reg;
        end
    end

    // zero opacity or zero radius: pass the pixel through untouched
    always_ff @(posedge clk)
    begin
        if (pass)
        begin
            red_out_reg   <= b1_pix_reg.red;
            green_out_reg <= b1_pix_reg.green;
            blue_out_reg  <= b1_pix_reg.blue;
        end
        else
        begin
            red_out_reg   <= (num_r[NUM_W-1:32] > 10'd255) ? 8'hFF : num_r[39:32];
            green_out_reg <= (num_g[NUM_W-1:32] > 10'd255) ? 8'hFF : num_g[39:32];
            blue_out_reg  <= (num_b[NUM_W-1:32] > 10'd255) ? 8'hFF : num_b[39:32];
        end
    end

    assign done      = out_vld_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##LATENCY done)
        else $error("accepted pixel did not come out after the fixed latency");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc, LATENCY))
        else $error("result strobe without a matching accepted pixel");

    a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ad_vld_reg[ADIV_STAGES-1] |-> (ad_q_reg <= ONE_Q16))
        else $error("alpha quotient above one");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pass) |-> (red_out == $past(red_in, LATENCY))
                         && (blue_out == $past(blue_in, LATENCY)))
        else $error("pass-through pixel altered");

endmodule

`default_nettype wire
